>>> hdl/binary_trie_max_xor_macros.svh
`ifndef BINARY_TRIE_MAX_XOR_MACROS_SVH
`define BINARY_TRIE_MAX_XOR_MACROS_SVH

// Condition that must hold at every clock edge out of reset
`define BTMX_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication
`define BTMX_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define BTMX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/btmx_pkg.sv
`default_nettype none

package btmx_pkg;

  // Default geometry
  localparam int WIDTH_DEF = 32;
  localparam int NODES_DEF = 4096;

  // Field widths fixed by the interface
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  // Item action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_WALK   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

endpackage

`default_nettype wire

>>> hdl/btmx_node_mem.sv
`default_nettype none

// Trie node store: one entry per node holding {link1, link0}.
// One write port, one read port with registered read data.
module btmx_node_mem #(
  parameter int NODES = 4096
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [$clog2(NODES)-1:0]    wr_addr,
  input  wire logic [2*$clog2(NODES)-1:0]  wr_data,
  input  wire logic                        rd_en,
  input  wire logic [$clog2(NODES)-1:0]    rd_addr,
  output logic      [2*$clog2(NODES)-1:0]  rd_data
);

  localparam int LW = $clog2(NODES);

  logic [2*LW-1:0] mem [NODES];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

>>> hdl/binary_trie_max_xor.sv
`default_nettype none

// Bitwise trie with maximum-XOR query. An item with action 0 inserts value,
// action 1 returns the largest XOR of value with any stored value. Every item
// gives exactly one result. An item that walks the trie handles one trie level
// per cycle, bounded by the single read port of the node memory, and then
// loads its result into the output register; the sequencer returns to idle as
// that register is loaded. An empty-trie query or a rejected insert skips the
// walk and goes straight to loading the output register. While an earlier
// result still waits on out_ready, the sequencer holds in its last step. One
// item is processed at a time; in_ready is high only while the sequencer is
// idle. The root's links live in flops, every other node is written in full
// when its first child is allocated and reads as empty until then, and leaf
// nodes are never read, so the node memory needs no clearing pass after
// reset. An insert is rejected (status full) when fewer than WIDTH nodes
// remain free.
module binary_trie_max_xor
  import btmx_pkg::*;
#(
  parameter int WIDTH = WIDTH_DEF,
  parameter int NODES = NODES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                action,
  input  wire logic [VALUE_W-1:0]  value,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [STATUS_W-1:0]      status,
  output logic [VALUE_W-1:0]       max_xor
);

  `include "binary_trie_max_xor_macros.svh"

  localparam int LW    = $clog2(NODES);
  localparam int FW    = $clog2(NODES + 1);
  localparam int LVW   = $clog2(WIDTH);
  localparam int LIMIT = NODES - WIDTH;

  // Control state
  state_t           state, state_next;
  logic [FW-1:0]    next_free, next_free_next;
  logic             has_entries, has_entries_next;
  logic [LW-1:0]    root0, root0_next;
  logic [LW-1:0]    root1, root1_next;
  logic             out_valid_next;

  // Walk state
  logic             act, act_next;
  logic [WIDTH-1:0] val_sh, val_sh_next;
  logic [WIDTH-1:0] acc, acc_next;
  logic [LVW-1:0]   lvl, lvl_next;
  logic [LW-1:0]    node, node_next;
  logic             fresh, fresh_next;
  logic             dead, dead_next;
  status_t          res_status, res_status_next;
  logic [VALUE_W-1:0] res_xor, res_xor_next;
  logic [STATUS_W-1:0] status_next;
  logic [VALUE_W-1:0]  max_xor_next;

  // Memory ports
  logic             wr_en;
  logic [LW-1:0]    wr_addr;
  logic [2*LW-1:0]  wr_data;
  logic             rd_en;
  logic [LW-1:0]    rd_addr;
  logic [2*LW-1:0]  rd_data;

  // Per-level decode
  logic [2*LW-1:0]  links;
  logic             bit_b;
  logic [LW-1:0]    link_b;
  logic [LW-1:0]    link_o;
  logic [LW-1:0]    free_node;
  logic [LW-1:0]    nxt;
  logic             acc_bit;
  logic             store_full;
  logic             out_free;

  btmx_node_mem #(
    .NODES (NODES)
  ) u_node_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Links of the current node: root in flops, fresh nodes have none
  assign links     = (node == '0) ? {root1, root0} : (fresh ? '0 : rd_data);
  assign bit_b     = val_sh[WIDTH-1];
  assign link_b    = bit_b ? links[2*LW-1:LW] : links[LW-1:0];
  assign link_o    = bit_b ? links[LW-1:0] : links[2*LW-1:LW];
  assign free_node = next_free[LW-1:0];
  assign store_full = next_free > FW'(LIMIT);

  // Sequencer
  always_comb begin
    state_next       = state;
    next_free_next   = next_free;
    has_entries_next = has_entries;
    root0_next       = root0;
    root1_next       = root1;
    act_next         = act;
    val_sh_next      = val_sh;
    acc_next         = acc;
    lvl_next         = lvl;
    node_next        = node;
    fresh_next       = fresh;
    dead_next        = dead;
    res_status_next  = res_status;
    res_xor_next     = res_xor;
    out_valid_next   = out_valid && !out_ready;
    status_next      = status;
    max_xor_next     = max_xor;
    wr_en            = 1'b0;
    wr_addr          = node;
    wr_data          = '0;
    rd_en            = 1'b0;
    nxt              = '0;
    acc_bit          = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          act_next     = action;
          val_sh_next  = WIDTH'(value);
          acc_next     = '0;
          lvl_next     = LVW'(WIDTH - 1);
          node_next    = '0;
          fresh_next   = 1'b0;
          dead_next    = 1'b0;
          res_xor_next = '0;
          if (action == ACT_INSERT && store_full) begin
            res_status_next = ST_FULL;
            state_next      = S_FINISH;
          end else if (action == ACT_QUERY && !has_entries) begin
            res_status_next = ST_EMPTY;
            state_next      = S_FINISH;
          end else begin
            res_status_next = ST_OK;
            state_next      = S_WALK;
          end
        end
      end

      S_WALK: begin
        if (act == ACT_INSERT) begin
          // Follow an existing branch, else allocate a child
          if (!fresh && link_b != '0) begin
            node_next = link_b;
            rd_en     = (lvl != '0);
          end else begin
            if (node == '0) begin
              if (bit_b) root1_next = free_node;
              else       root0_next = free_node;
            end else begin
              wr_en   = 1'b1;
              wr_data = bit_b ? {free_node, link_o} : {link_o, free_node};
            end
            next_free_next = next_free + FW'(1);
            node_next      = free_node;
            fresh_next     = 1'b1;
          end
        end else if (!dead) begin
          // Prefer the opposite branch
          if (link_o != '0) begin
            acc_bit = 1'b1;
            nxt     = link_o;
          end else begin
            nxt = link_b;
          end
          if (nxt == '0) begin
            dead_next = 1'b1;
          end else begin
            node_next = nxt;
            rd_en     = (lvl != '0);
          end
        end
        acc_next    = {acc[WIDTH-2:0], acc_bit};
        val_sh_next = val_sh << 1;
        lvl_next    = lvl - LVW'(1);
        if (lvl == '0) begin
          res_xor_next = VALUE_W'(acc_next);
          if (act == ACT_INSERT) has_entries_next = 1'b1;
          state_next = S_FINISH;
        end
      end

      S_FINISH: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          status_next    = res_status;
          max_xor_next   = res_xor;
          state_next     = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign rd_addr = node_next;

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      next_free   <= FW'(1);
      has_entries <= 1'b0;
      root0       <= '0;
      root1       <= '0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      next_free   <= next_free_next;
      has_entries <= has_entries_next;
      root0       <= root0_next;
      root1       <= root1_next;
      out_valid   <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    act        <= act_next;
    val_sh     <= val_sh_next;
    acc        <= acc_next;
    lvl        <= lvl_next;
    node       <= node_next;
    fresh      <= fresh_next;
    dead       <= dead_next;
    res_status <= res_status_next;
    res_xor    <= res_xor_next;
    status     <= status_next;
    max_xor    <= max_xor_next;
  end

  // Checks
  `BTMX_ASSERT_ALWAYS(a_free_bound, next_free <= FW'(NODES), "free counter past node store")
  `BTMX_ASSERT_IMPL(a_wr_alloc, wr_en, FW'(wr_addr) < next_free, "write to unallocated node")
  `BTMX_ASSERT_IMPL(a_rd_alloc, rd_en, FW'(rd_addr) < next_free, "read of unallocated node")
  `BTMX_ASSERT_NEXT(a_grow_one, state == S_WALK && act == ACT_INSERT && fresh,
                    next_free == $past(next_free) + FW'(1), "fresh node must allocate one")
  `BTMX_ASSERT_IMPL(a_err_zero, out_valid && status != ST_OK, max_xor == '0,
                    "error result carries nonzero xor")

endmodule

`default_nettype wire
